// File: rtl/sorted_set_priority_queue_core_macros.svh
// Assertion macros for the sorted set priority queue.
// Used by the top level; relies on clk and arst_n being in scope.
`ifndef SORTED_SET_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_SET_PRIORITY_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SSPQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sspq assertion failed");
`define SSPQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sspq assertion failed");
`else
`define SSPQ_ASSERT_IMP(lbl, ante, cons)
`define SSPQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/sspq_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted set priority queue: sizes, codes and item types.
// No dependencies.
package sspq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int VAL_W = 32;
	localparam int CNT_FIELD_W = 5;
	localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_IGNORED = 3'd1,
		ST_FULL = 3'd2,
		ST_POPPED = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	typedef struct packed {
		op_t op;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] popped_value;
		status_t status;
		logic [CNT_FIELD_W-1:0] count;
	} res_t;

	typedef struct packed {
		logic shift_in;
		logic shift_out;
	} cell_ctrl_t;

endpackage

// File: rtl/sspq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the sorted chain: compares the broadcast value with its own
// and shifts toward either neighbor. Depends on sspq_pkg.
module sspq_cell import sspq_pkg::*; (
	input logic clk,
	input cell_ctrl_t ctrl,
	input logic signed [VAL_W-1:0] key,
	input logic occupied,
	input logic left_lt,
	input logic signed [VAL_W-1:0] left_val,
	input logic signed [VAL_W-1:0] right_val,
	output logic signed [VAL_W-1:0] val,
	output logic lt,
	output logic eq
);

	logic signed [VAL_W-1:0] val_q;

	assign val = val_q;
	assign lt = occupied && (val_q < key);
	assign eq = occupied && (val_q == key);

	always_ff @(posedge clk) begin
		if (ctrl.shift_in) begin
			if (!lt) begin
				val_q <= left_lt ? key : left_val;
			end
		end else if (ctrl.shift_out) begin
			val_q <= right_val;
		end
	end

endmodule

// File: rtl/sorted_set_priority_queue_core.sv
`timescale 1ns / 1ps
// Sorted set priority queue: holds up to CAPACITY distinct signed 32-bit values in
// ascending order in a row of compare-and-shift cells. One item (an insert or a pop) is
// accepted every cycle while the block does not stall; its result appears in the output
// register in the cycle after acceptance. The block stalls only while that register holds
// a result that the receiver has not yet taken. Depends on sspq_pkg and sspq_cell.
`include "sorted_set_priority_queue_core_macros.svh"
module sorted_set_priority_queue_core import sspq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input cmd_t cmd,
	output logic res_valid,
	input logic res_stall,
	output res_t res
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic res_valid_q;
	res_t res_q;
	res_t res_next;
	cell_ctrl_t ctrl;
	logic accept;
	logic any_eq;
	logic is_empty;
	logic is_full;
	logic is_sentinel;
	logic [CAPACITY-1:0] occ;
	logic [CAPACITY-1:0] lt;
	logic [CAPACITY-1:0] eq;
	logic signed [VAL_W-1:0] vals [CAPACITY];

	assign cmd_stall = res_valid_q && res_stall;
	assign accept = cmd_valid && !cmd_stall;
	assign res_valid = res_valid_q;
	assign res = res_q;

	assign any_eq = |eq;
	assign is_empty = (count_q == '0);
	assign is_full = (count_q == CNT_W'(CAPACITY));
	assign is_sentinel = (cmd.value == INT_MAX);

	always_comb begin
		res_next.popped_value = '0;
		res_next.status = ST_INSERTED;
		count_next = count_q;
		case (cmd.op)
			OP_POP: begin
				if (is_empty) begin
					res_next.status = ST_EMPTY;
				end else begin
					res_next.status = ST_POPPED;
					res_next.popped_value = vals[0];
					count_next = count_q - CNT_W'(1);
				end
			end
			OP_INSERT: begin
				if (is_sentinel || any_eq) begin
					res_next.status = ST_IGNORED;
				end else if (is_full) begin
					res_next.status = ST_FULL;
				end else begin
					count_next = count_q + CNT_W'(1);
				end
			end
			default: begin
				res_next.status = ST_IGNORED;
			end
		endcase
		res_next.count = CNT_FIELD_W'(count_next);
	end

	assign ctrl.shift_in = accept && (cmd.op == OP_INSERT) && (res_next.status == ST_INSERTED);
	assign ctrl.shift_out = accept && (cmd.op == OP_POP) && !is_empty;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic left_lt;
		logic signed [VAL_W-1:0] left_val;
		logic signed [VAL_W-1:0] right_val;

		assign occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_lt = 1'b1;
			assign left_val = cmd.value;
		end else begin : g_body
			assign left_lt = lt[i-1];
			assign left_val = vals[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_val = vals[i];
		end else begin : g_inner
			assign right_val = vals[i+1];
		end

		sspq_cell u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.key(cmd.value),
			.occupied(occ[i]),
			.left_lt(left_lt),
			.left_val(left_val),
			.right_val(right_val),
			.val(vals[i]),
			.lt(lt[i]),
			.eq(eq[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_next;
		end
	end

	`SSPQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY))
	`SSPQ_ASSERT_IMP(a_insert_room, ctrl.shift_in, !lt[CAPACITY-1] && !is_full)
	`SSPQ_ASSERT_NXT(a_pop_head, ctrl.shift_out, res.popped_value == $past(vals[0]))
	`SSPQ_ASSERT_NXT(a_hold_result, res_valid && res_stall, res_valid && $stable(res))

endmodule
